// ===== hdl/icd_pkg.sv =====
// Shared types, request codes and helper functions for the interrupt controller.
// No dependencies; every other file in this block but icd_if imports it.
package icd_pkg;

    localparam logic [3:0] REQ_WR_ENABLE  = 4'd0;
    localparam logic [3:0] REQ_WR_REQUEST = 4'd1;
    localparam logic [3:0] REQ_RAISE      = 4'd2;
    localparam logic [3:0] REQ_CLEAR      = 4'd3;
    localparam logic [3:0] REQ_EI         = 4'd4;
    localparam logic [3:0] REQ_RETI_EN    = 4'd5;
    localparam logic [3:0] REQ_DI         = 4'd6;
    localparam logic [3:0] REQ_INSTR_STEP = 4'd7;
    localparam logic [3:0] REQ_HALT_EXIT  = 4'd8;
    localparam logic [3:0] REQ_DISPATCH   = 4'd9;

    localparam logic       REQUEST_UNUSED_HIGH = 1'b1;
    localparam logic [7:0] REQUEST_HIGH_BITS   = 8'hE0;
    localparam logic [15:0] VECTOR_BASE        = 16'h0040;
    localparam logic [4:0] CYCLES_HALT         = 5'd24;
    localparam logic [4:0] CYCLES_NORMAL       = 5'd20;

    typedef enum logic [1:0] {
        MS_DISABLED = 2'd0,
        MS_DELAYED  = 2'd1,
        MS_ENABLED  = 2'd2
    } master_t;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [7:0]  data_byte;
        logic [4:0]  flag_mask;
        logic [15:0] pc;
        logic [15:0] sp;
    } req_t;

    typedef struct packed {
        logic [7:0]  enable_read;
        logic [7:0]  request_read;
        logic [1:0]  master_state;
        logic        dispatched;
        logic [15:0] new_pc;
        logic [15:0] new_sp;
        logic [7:0]  push_hi_data;
        logic [7:0]  push_lo_data;
        logic [4:0]  cycle_count;
        logic [4:0]  served_mask;
        logic        dispatch_error;
    } rsp_t;

    typedef struct packed {
        logic [7:0] enable;
        logic [7:0] request;
        master_t    master;
        logic       halt;
    } state_t;

    function automatic logic [2:0] lowest_bit(input logic [4:0] pend);
        logic [2:0] idx;
        idx = 3'd4;
        for (int i = 3; i >= 0; i--)
        begin
            if (pend[i])
            begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    function automatic logic [7:0] request_view(input logic [7:0] value);
        return REQUEST_UNUSED_HIGH ? (value | REQUEST_HIGH_BITS) : value;
    endfunction

endpackage

// ===== hdl/icd_if.sv =====
// Request and result channel interfaces of the interrupt controller.
// Depends on icd_pkg for nothing but field widths, which are written out here.
interface icd_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  req_type;
    logic [7:0]  data_byte;
    logic [4:0]  flag_mask;
    logic [15:0] pc;
    logic [15:0] sp;

    modport source (output valid, req_type, data_byte, flag_mask, pc, sp, input ready);
    modport sink   (input valid, req_type, data_byte, flag_mask, pc, sp, output ready);
endinterface

interface icd_rsp_if;
    logic        valid;
    logic        ready;
    logic [7:0]  enable_read;
    logic [7:0]  request_read;
    logic [1:0]  master_state;
    logic        dispatched;
    logic [15:0] new_pc;
    logic [15:0] new_sp;
    logic [7:0]  push_hi_data;
    logic [7:0]  push_lo_data;
    logic [4:0]  cycle_count;
    logic [4:0]  served_mask;
    logic        dispatch_error;

    modport source (output valid, enable_read, request_read, master_state, dispatched,
                    new_pc, new_sp, push_hi_data, push_lo_data, cycle_count,
                    served_mask, dispatch_error, input ready);
    modport sink   (input valid, enable_read, request_read, master_state, dispatched,
                    new_pc, new_sp, push_hi_data, push_lo_data, cycle_count,
                    served_mask, dispatch_error, output ready);
endinterface

// ===== hdl/interrupt_controller_dispatch.sv =====
// Top level of the interrupt controller with dispatch.
// Depends on icd_pkg, the channel interfaces in icd_if and the icd_eval module.
//
// Requests arrive on the req channel and each one produces exactly one result
// on the rsp channel, in order. A request carries a kind code, a data byte,
// a request-flag mask and the CPU's current PC and SP; the result reports the
// enable and request registers and the master-enable state after the request,
// plus the vector, new SP, pushed bytes, cycle cost and served flag of a
// dispatch.
// A request is captured in an input register, evaluated combinationally
// against the controller state and stored in the result register, which
// presents it on the rsp channel. One request is accepted every cycle as long
// as the receiver takes results.
// When the receiver stalls, the result register holds its value and the input
// register keeps the next request; the req channel lowers ready only when both
// are full. State updates happen when a request moves into the result register.
// Reset clears the enable and request registers, the halt-exit marker and both
// valid flags, and sets the master enable to disabled.
module interrupt_controller_dispatch (
    input  logic         clk,
    input  logic         rst_n,
    icd_req_if.sink      req,
    icd_rsp_if.source    rsp
);
    import icd_pkg::*;

    req_t   in_reg;
    logic   in_valid_reg;
    rsp_t   out_reg;
    logic   out_valid_reg;
    state_t state_reg;
    state_t state_next;
    rsp_t   res_next;
    req_t   req_data;
    logic   advance;

    assign advance   = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || advance;
    assign req_data  = '{req_type:  req.req_type,
                         data_byte: req.data_byte,
                         flag_mask: req.flag_mask,
                         pc:        req.pc,
                         sp:        req.sp};

    icd_eval u_eval (
        .st  (state_reg),
        .rq  (in_reg),
        .nxt (state_next),
        .res (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= '{enable: 8'd0, request: 8'd0, master: MS_DISABLED, halt: 1'b0};
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
                state_reg     <= state_next;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            in_reg <= req_data;
        end
        if (advance)
        begin
            out_reg <= res_next;
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.enable_read    = out_reg.enable_read;
    assign rsp.request_read   = out_reg.request_read;
    assign rsp.master_state   = out_reg.master_state;
    assign rsp.dispatched     = out_reg.dispatched;
    assign rsp.new_pc         = out_reg.new_pc;
    assign rsp.new_sp         = out_reg.new_sp;
    assign rsp.push_hi_data   = out_reg.push_hi_data;
    assign rsp.push_lo_data   = out_reg.push_lo_data;
    assign rsp.cycle_count    = out_reg.cycle_count;
    assign rsp.served_mask    = out_reg.served_mask;
    assign rsp.dispatch_error = out_reg.dispatch_error;

endmodule

// ===== hdl/icd_eval.sv =====
// Combinational evaluation of one request against the controller state.
// Depends on icd_pkg for types, request codes and the priority encoder.
module icd_eval (
    input  icd_pkg::state_t st,
    input  icd_pkg::req_t   rq,
    output icd_pkg::state_t nxt,
    output icd_pkg::rsp_t   res
);
    import icd_pkg::*;

    logic [4:0] pend;
    logic [4:0] pend2;
    logic [2:0] bit1;
    logic [2:0] bit2;
    logic [4:0] flag1;
    logic [4:0] flag2;
    logic [7:0] hi;
    logic [7:0] lo;

    assign hi    = rq.pc[15:8];
    assign lo    = rq.pc[7:0];
    assign pend  = st.enable[4:0] & st.request[4:0];
    assign pend2 = hi[4:0] & st.request[4:0];
    assign bit1  = lowest_bit(pend);
    assign bit2  = lowest_bit(pend2);
    assign flag1 = 5'd1 << bit1;
    assign flag2 = 5'd1 << bit2;

    always_comb
    begin
        nxt = st;
        res = '0;
        unique case (rq.req_type)
            REQ_WR_ENABLE:  nxt.enable = rq.data_byte;
            REQ_WR_REQUEST: nxt.request = request_view(rq.data_byte);
            REQ_RAISE:      nxt.request = st.request | {3'b000, rq.flag_mask};
            REQ_CLEAR:      nxt.request = st.request & ~{3'b000, rq.flag_mask};
            REQ_EI:
            begin
                if (st.master != MS_ENABLED)
                begin
                    nxt.master = MS_DELAYED;
                end
            end
            REQ_RETI_EN:    nxt.master = MS_ENABLED;
            REQ_DI:         nxt.master = MS_DISABLED;
            REQ_INSTR_STEP:
            begin
                if (st.master == MS_DELAYED)
                begin
                    nxt.master = MS_ENABLED;
                end
            end
            REQ_HALT_EXIT:  nxt.halt = 1'b1;
            REQ_DISPATCH:
            begin
                if (pend == 5'd0)
                begin
                    res.dispatch_error = 1'b1;
                end
                else
                begin
                    res.cycle_count  = st.halt ? CYCLES_HALT : CYCLES_NORMAL;
                    nxt.halt         = 1'b0;
                    nxt.master       = MS_DISABLED;
                    res.new_sp       = rq.sp - 16'd2;
                    res.push_hi_data = hi;
                    res.push_lo_data = lo;
                    res.dispatched   = 1'b1;
                    if (rq.sp == 16'd0)
                    begin
                        nxt.enable = hi;
                    end
                    else if (rq.sp == 16'd1)
                    begin
                        nxt.enable = lo;
                    end
                    if (rq.sp == 16'd0 && (flag1 & hi[4:0]) == 5'd0)
                    begin
                        if (pend2 != 5'd0)
                        begin
                            res.new_pc      = VECTOR_BASE + {10'd0, bit2, 3'd0};
                            nxt.request     = st.request & ~{3'b000, flag2};
                            res.served_mask = flag2;
                        end
                    end
                    else
                    begin
                        res.new_pc      = VECTOR_BASE + {10'd0, bit1, 3'd0};
                        nxt.request     = st.request & ~{3'b000, flag1};
                        res.served_mask = flag1;
                    end
                end
            end
            default: ;
        endcase
        res.enable_read  = nxt.enable;
        res.request_read = request_view(nxt.request);
        res.master_state = nxt.master;
    end

endmodule

// ===== bench/icd_checker.sv =====
// Checker for the interrupt controller: watches the request and result channels,
// predicts each result from its own copy of the controller state and compares.
// Depends on icd_pkg and the channel interfaces in icd_if.
module icd_checker (
    input  logic clk,
    input  logic rst_n,
    icd_req_if   req,
    icd_rsp_if   rsp,
    output int   mismatch_count,
    output int   expected_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import icd_pkg::*;

    logic [7:0] ctl_enable;
    logic [7:0] ctl_request;
    master_t    ctl_master;
    logic       ctl_halt;
    rsp_t       expected_rsp[$];
    req_t       seen_req;
    rsp_t       want;

    initial
    begin
        mismatch_count = 0;
        expected_count = 0;
    end

    function automatic logic [2:0] first_pending(input logic [4:0] pend);
        logic [2:0] idx;
        idx = 3'd4;
        for (int i = 4; i >= 0; i--)
        begin
            if (pend[i])
            begin
                idx = 3'(i);
            end
        end
        return idx;
    endfunction

    function automatic rsp_t serve_request(input req_t r);
        rsp_t       o;
        logic [4:0] pend;
        logic [4:0] flag;
        logic [4:0] pend2;
        logic [2:0] idx;
        logic [2:0] idx2;
        logic [7:0] hi;
        logic [7:0] lo;
        o = '0;
        unique case (r.req_type)
            REQ_WR_ENABLE:  ctl_enable = r.data_byte;
            REQ_WR_REQUEST: ctl_request = REQUEST_UNUSED_HIGH ?
                                          (r.data_byte | REQUEST_HIGH_BITS) : r.data_byte;
            REQ_RAISE:      ctl_request = ctl_request | {3'b000, r.flag_mask};
            REQ_CLEAR:      ctl_request = ctl_request & ~{3'b000, r.flag_mask};
            REQ_EI:
            begin
                if (ctl_master != MS_ENABLED)
                begin
                    ctl_master = MS_DELAYED;
                end
            end
            REQ_RETI_EN:    ctl_master = MS_ENABLED;
            REQ_DI:         ctl_master = MS_DISABLED;
            REQ_INSTR_STEP:
            begin
                if (ctl_master == MS_DELAYED)
                begin
                    ctl_master = MS_ENABLED;
                end
            end
            REQ_HALT_EXIT:  ctl_halt = 1'b1;
            REQ_DISPATCH:
            begin
                pend = ctl_enable[4:0] & ctl_request[4:0];
                if (pend == 5'd0)
                begin
                    o.dispatch_error = 1'b1;
                end
                else
                begin
                    idx = first_pending(pend);
                    flag = 5'd1 << idx;
                    hi = r.pc[15:8];
                    lo = r.pc[7:0];
                    o.cycle_count = ctl_halt ? CYCLES_HALT : CYCLES_NORMAL;
                    ctl_halt = 1'b0;
                    ctl_master = MS_DISABLED;
                    if (r.sp == 16'd0)
                    begin
                        ctl_enable = hi;
                    end
                    else if (r.sp == 16'd1)
                    begin
                        ctl_enable = lo;
                    end
                    if (r.sp == 16'd0 && (flag & hi[4:0]) == 5'd0)
                    begin
                        pend2 = ctl_enable[4:0] & ctl_request[4:0];
                        if (pend2 != 5'd0)
                        begin
                            idx2 = first_pending(pend2);
                            o.new_pc = VECTOR_BASE + {10'd0, idx2, 3'b000};
                            ctl_request[idx2] = 1'b0;
                            o.served_mask = 5'd1 << idx2;
                        end
                    end
                    else
                    begin
                        o.new_pc = VECTOR_BASE + {10'd0, idx, 3'b000};
                        ctl_request = ctl_request & ~{3'b000, flag};
                        o.served_mask = flag;
                    end
                    o.new_sp = r.sp - 16'd2;
                    o.push_hi_data = hi;
                    o.push_lo_data = lo;
                    o.dispatched = 1'b1;
                end
            end
            default: ;
        endcase
        o.enable_read = ctl_enable;
        o.request_read = REQUEST_UNUSED_HIGH ? (ctl_request | REQUEST_HIGH_BITS) : ctl_request;
        o.master_state = ctl_master;
        return o;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] exp_v,
                                        input logic [15:0] act_v);
        if (exp_v !== act_v)
        begin
            if (mismatch_count < 10)
            begin
                $display("mismatch on %s: expected %h, actual %h", name, exp_v, act_v);
            end
            mismatch_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_enable = 8'h00;
            ctl_request = 8'h00;
            ctl_master = MS_DISABLED;
            ctl_halt = 1'b0;
            expected_rsp.delete();
            expected_count = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (expected_rsp.size() == 0)
                begin
                    if (mismatch_count < 10)
                    begin
                        $display("result arrived with no request outstanding");
                    end
                    mismatch_count++;
                end
                else
                begin
                    want = expected_rsp.pop_front();
                    check_field("enable_read", 16'(want.enable_read),
                                16'(rsp.enable_read));
                    check_field("request_read", 16'(want.request_read),
                                16'(rsp.request_read));
                    check_field("master_state", 16'(want.master_state),
                                16'(rsp.master_state));
                    check_field("dispatched", 16'(want.dispatched),
                                16'(rsp.dispatched));
                    check_field("new_pc", want.new_pc, rsp.new_pc);
                    check_field("new_sp", want.new_sp, rsp.new_sp);
                    check_field("push_hi_data", 16'(want.push_hi_data),
                                16'(rsp.push_hi_data));
                    check_field("push_lo_data", 16'(want.push_lo_data),
                                16'(rsp.push_lo_data));
                    check_field("cycle_count", 16'(want.cycle_count),
                                16'(rsp.cycle_count));
                    check_field("served_mask", 16'(want.served_mask),
                                16'(rsp.served_mask));
                    check_field("dispatch_error", 16'(want.dispatch_error),
                                16'(rsp.dispatch_error));
                end
            end
            if (req.valid && req.ready)
            begin
                seen_req.req_type = req.req_type;
                seen_req.data_byte = req.data_byte;
                seen_req.flag_mask = req.flag_mask;
                seen_req.pc = req.pc;
                seen_req.sp = req.sp;
                expected_rsp.push_back(serve_request(seen_req));
            end
            expected_count = expected_rsp.size();
        end
    end

endmodule

// ===== bench/interrupt_controller_dispatch_tb.sv =====
// Testbench top for the interrupt controller: clock, reset, directed and random
// request streams with idle and stall bursts, and the final verdict.
// Depends on icd_pkg, icd_if, icd_checker and the interrupt_controller_dispatch block.
module interrupt_controller_dispatch_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import icd_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int RANDOM_ITEMS = 700;
    localparam int CALM_AFTER = 600;

    logic clk;
    logic rst_n;
    logic calm;
    int   mismatch_count;
    int   expected_count;
    int   cycles_elapsed;
    int   items_sent;
    int   ready_hold;
    logic stalling;

    icd_req_if req_ch();
    icd_rsp_if rsp_ch();

    interrupt_controller_dispatch DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    icd_checker checker_i (
        .clk            (clk),
        .rst_n          (rst_n),
        .req            (req_ch),
        .rsp            (rsp_ch),
        .mismatch_count (mismatch_count),
        .expected_count (expected_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles_elapsed++;
        if (cycles_elapsed > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    function automatic logic [15:0] pick_sp();
        unique case ($urandom_range(0, 7))
            0: return 16'h0000;
            1: return 16'h0001;
            2: return 16'h0002;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_request(input logic [3:0] kind, input logic [7:0] data,
                                input logic [4:0] mask, input logic [15:0] pc,
                                input logic [15:0] sp);
        req_ch.valid <= 1'b1;
        req_ch.req_type <= kind;
        req_ch.data_byte <= data;
        req_ch.flag_mask <= mask;
        req_ch.pc <= pc;
        req_ch.sp <= sp;
        do
        begin
            @(posedge clk);
        end
        while (!req_ch.ready);
        if (kind <= REQ_DISPATCH)
        begin
            items_sent++;
        end
        if (!calm && $urandom_range(0, 3) == 0)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic send_kind(input logic [3:0] kind);
        send_request(kind, 8'($urandom), 5'($urandom), 16'($urandom), pick_sp());
    endtask

    task automatic run_episode();
        if ($urandom_range(0, 1) == 0)
        begin
            send_kind(REQ_WR_ENABLE);
        end
        send_kind(REQ_RAISE);
        if ($urandom_range(0, 3) == 0)
        begin
            send_kind(REQ_HALT_EXIT);
        end
        if ($urandom_range(0, 1) == 0)
        begin
            send_kind(REQ_EI);
            send_kind(REQ_INSTR_STEP);
        end
        else
        begin
            send_kind(REQ_RETI_EN);
        end
        send_kind(REQ_DISPATCH);
        if ($urandom_range(0, 9) < 3)
        begin
            send_kind(REQ_DISPATCH);
        end
        if ($urandom_range(0, 4) == 0)
        begin
            send_kind($urandom_range(0, 1) ? REQ_CLEAR : REQ_DI);
        end
    endtask

    initial
    begin
        stalling = 1'b0;
        ready_hold = 0;
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (calm)
            begin
                rsp_ch.ready <= 1'b1;
            end
            else if (ready_hold > 0)
            begin
                ready_hold--;
            end
            else
            begin
                stalling = !stalling;
                if (stalling)
                begin
                    rsp_ch.ready <= 1'b0;
                    ready_hold = $urandom_range(1, 16) - 1;
                end
                else
                begin
                    rsp_ch.ready <= 1'b1;
                    ready_hold = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 80)
                                                             : $urandom_range(0, 12);
                end
            end
        end
    end

    initial
    begin
        calm = 1'b0;
        cycles_elapsed = 0;
        items_sent = 0;
        rst_n <= 1'b0;
        req_ch.valid <= 1'b0;
        req_ch.req_type <= REQ_WR_ENABLE;
        req_ch.data_byte <= 8'h00;
        req_ch.flag_mask <= 5'h00;
        req_ch.pc <= 16'h0000;
        req_ch.sp <= 16'h0000;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(REQ_DISPATCH, 8'h00, 5'h00, 16'h1234, 16'h8000);
        send_request(REQ_WR_ENABLE, 8'hFF, 5'h00, 16'h0000, 16'h0000);
        send_request(REQ_WR_REQUEST, 8'h00, 5'h1F, 16'hFFFF, 16'hFFFF);
        send_request(REQ_RAISE, 8'hFF, 5'h1F, 16'h0000, 16'h0000);
        send_request(REQ_HALT_EXIT, 8'h00, 5'h00, 16'h0000, 16'h0000);
        send_request(REQ_EI, 8'h00, 5'h00, 16'h0000, 16'h0000);
        send_request(REQ_INSTR_STEP, 8'h00, 5'h00, 16'h0000, 16'h0000);
        send_request(REQ_EI, 8'h00, 5'h00, 16'h0000, 16'h0000);
        send_request(REQ_DISPATCH, 8'h00, 5'h00, 16'hFFFF, 16'hFFFF);
        send_request(REQ_DI, 8'h00, 5'h00, 16'h0000, 16'h0000);
        send_request(REQ_INSTR_STEP, 8'h00, 5'h00, 16'h0000, 16'h0000);
        send_request(REQ_RETI_EN, 8'h00, 5'h00, 16'h0000, 16'h0000);
        send_request(REQ_DISPATCH, 8'h00, 5'h00, 16'h0000, 16'h0000);
        send_request(REQ_WR_ENABLE, 8'h1F, 5'h00, 16'h0000, 16'h0000);
        send_request(REQ_DISPATCH, 8'h00, 5'h00, 16'h0400, 16'h0000);
        send_request(REQ_WR_ENABLE, 8'hFF, 5'h00, 16'h0000, 16'h0000);
        send_request(REQ_DISPATCH, 8'h00, 5'h00, 16'h0201, 16'h0001);
        send_request(REQ_WR_ENABLE, 8'h18, 5'h00, 16'h0000, 16'h0000);
        send_request(REQ_DISPATCH, 8'h00, 5'h00, 16'h0800, 16'h0000);
        send_request(REQ_CLEAR, 8'h00, 5'h1F, 16'h0000, 16'h0000);
        send_request(REQ_WR_REQUEST, 8'hFF, 5'h00, 16'h0000, 16'h0000);
        for (int k = REQ_DISPATCH + 1; k <= 15; k++)
        begin
            send_request(4'(k), 8'hFF, 5'h1F, 16'hFFFF, 16'hFFFF);
        end
        send_request(REQ_WR_ENABLE, 8'h00, 5'h00, 16'h0000, 16'h0000);

        items_sent = 0;
        while (items_sent < RANDOM_ITEMS)
        begin
            if (items_sent >= CALM_AFTER)
            begin
                calm = 1'b1;
            end
            if ($urandom_range(0, 9) < 7)
            begin
                run_episode();
            end
            else
            begin
                send_kind(4'($urandom_range(0, 15)));
            end
        end
        req_ch.valid <= 1'b0;

        while (expected_count != 0)
        begin
            @(posedge clk);
        end
        repeat (8) @(posedge clk);
        if (mismatch_count == 0)
        begin
            $display("PASS");
        end
        else
        begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
